/* rtl/core/mru_pkg.sv */
// Shared types and constants for the MRU order list.
package mru_pkg;

	localparam int unsigned ID_W = 29;

	typedef enum logic [1:0] {
		FN_TOUCH  = 2'd0,
		FN_FORGET = 2'd1,
		FN_QUERY  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_ACTIVE = 2'd0,
		PH_REMOVE = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic              tok;
		func_t             func;
		phase_t            phase;
		logic [ID_W-1:0]   key;
		logic [ID_W-1:0]   data;
		logic              found;
		logic              grow;
		logic              shrink;
	} link_t;

endpackage

/* rtl/core/mru_cell.sv */
// One list position: holds an entry and processes the token passing along the row.
module mru_cell import mru_pkg::*; #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CW    = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CW-1:0]   count,
	input  link_t           link_in,
	input  logic [ID_W-1:0] nb_entry,
	input  logic            nb_last,
	output logic [ID_W-1:0] entry,
	output link_t           link_out
);

	logic [ID_W-1:0] entry_q;
	link_t           link_q;
	link_t           link_d;
	logic            wr;
	logic [ID_W-1:0] wdata;
	logic            valid;
	logic            nb_valid;

	assign valid    = CW'(INDEX) < count;
	assign nb_valid = !nb_last && (CW'(INDEX + 1) < count);

	always_comb begin
		link_d = link_in;
		wr     = 1'b0;
		wdata  = link_in.data;
		if (link_in.tok) begin
			case (link_in.phase)
				PH_ACTIVE: begin
					case (link_in.func)
						FN_TOUCH: begin
							wr = 1'b1;
							if (!valid) begin
								link_d.phase = PH_DONE;
								link_d.grow  = 1'b1;
							end else if (entry_q == link_in.key) begin
								link_d.phase = PH_DONE;
							end else begin
								link_d.data = entry_q;
							end
						end
						FN_FORGET: begin
							if (!valid) begin
								link_d.phase = PH_DONE;
							end else if (entry_q == link_in.data) begin
								wr            = 1'b1;
								wdata         = nb_entry;
								link_d.shrink = 1'b1;
								link_d.phase  = nb_valid ? PH_REMOVE : PH_DONE;
							end
						end
						FN_QUERY: begin
							if (!valid) begin
								link_d.phase = PH_DONE;
							end else if (entry_q != link_in.data) begin
								link_d.phase = PH_DONE;
								link_d.found = 1'b1;
								link_d.data  = entry_q;
							end
						end
						default: begin
							link_d.phase = PH_DONE;
						end
					endcase
				end
				PH_REMOVE: begin
					wr    = 1'b1;
					wdata = nb_entry;
					if (!nb_valid) begin
						link_d.phase = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_d;
		end
	end

	assign entry    = entry_q;
	assign link_out = link_q;

endmodule

/* rtl/core/mru_order_list.sv */
// Top level of the MRU order list: command port, entry count and the row of cells.
// Each transaction (touch, forget, query) launches a token into a row of DEPTH cells;
// the token moves one cell per clock, shifting entries as it goes, and the result
// is registered once it leaves the last cell. busy stays high until the result cycle
// and is low while done is high, so a new start can be taken at the edge that ends the
// result. The result is shown for exactly one cycle with done high; found and
// result_window keep it until the next transaction's result.
module mru_order_list import mru_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [1:0]      func,
	input  logic [ID_W-1:0] window,
	output logic            done,
	output logic            found,
	output logic [ID_W-1:0] result_window,
	output logic [CW-1:0]   entry_count
);

	link_t           chain [DEPTH+1];
	logic [ID_W-1:0] entries [DEPTH];
	logic            busy_q;
	logic            done_q;
	logic            found_q;
	logic [ID_W-1:0] result_q;
	logic [CW-1:0]   count_q;
	logic            accept;
	func_t           fn;
	link_t           tail;

	assign accept = start && !busy_q;
	assign fn     = func_t'(func);
	assign tail   = chain[DEPTH];

	always_comb begin
		chain[0].tok    = accept;
		chain[0].func   = fn;
		chain[0].key    = window;
		chain[0].data   = window;
		chain[0].found  = 1'b0;
		chain[0].grow   = 1'b0;
		chain[0].shrink = 1'b0;
		if ((fn == FN_NONE) || ((fn != FN_QUERY) && (window == '0))) begin
			chain[0].phase = PH_DONE;
		end else begin
			chain[0].phase = PH_ACTIVE;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mru_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_q),
			.link_in (chain[i]),
			.nb_entry(entries[(i + 1 < DEPTH) ? i + 1 : i]),
			.nb_last (i + 1 >= DEPTH),
			.entry   (entries[i]),
			.link_out(chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= tail.tok;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.tok) begin
				busy_q <= 1'b0;
			end
			if (tail.tok) begin
				if (tail.grow) begin
					count_q <= count_q + CW'(1);
				end else if (tail.shrink) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.tok) begin
			found_q  <= tail.found;
			result_q <= tail.found ? tail.data : '0;
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign found         = found_q;
	assign result_window = result_q;
	assign entry_count   = count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without a transaction in flight");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> result_window != '0)
		else $error("query returned id zero");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> !done || (entry_count == $past(entry_count))
			|| (entry_count == $past(entry_count) + CW'(1))
			|| (entry_count == $past(entry_count) - CW'(1)))
		else $error("entry count moved by more than one");

endmodule
